// File: hw/rtl/kvm_pkg.sv
`timescale 1ns / 1ps

package kvm_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int OP_W    = 3;

  localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_ENUM   = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

// File: hw/rtl/linear_key_value_map_top.sv
`timescale 1ns / 1ps

// Fixed-capacity key/value table, searched slot by slot.
// Input channel: a transaction (in_opcode, in_key, in_value) is taken at a
// rising edge where start is high and busy is low. busy stays high while a
// get, set, remove or enumerate scans the key memory.
// Result channel: out_valid marks each result for exactly one cycle; the
// receiver cannot stall, so results are never held back. out_last marks the
// final result of a transaction.
// Answers: clear, unknown opcodes, the reserved all-ones key and an
// enumerate of an empty table answer in the cycle after acceptance. Get,
// set and remove read one slot per cycle from the key and value memories
// (registered read) and answer on a hit or once the last slot within
// capacity is checked. Enumerate gives one result per occupied slot as the
// scan passes it. The memory read port, one slot a cycle, sets the rate: a
// lookup that misses keeps busy high while it scans every slot within
// capacity, and no new transaction is taken until busy falls.
// Configuration: cfg_we writes cfg_capacity_in_use; write only while idle.
// Reset: every slot empty through per-slot occupied flags cleared at once,
// count zero, capacity 16. No clearing pass; items are taken right away.
module linear_key_value_map_top
  import kvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic             out_ok,
  output logic [KEY_W-1:0] out_key_out,
  output logic [VAL_W-1:0] out_value_out,
  output logic [CNT_W-1:0] out_entry_count,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_capacity_in_use
);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0]    cap_r;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [VAL_W-1:0]    out_val_r, out_val_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                out_last_r, out_last_nxt;

  logic [KEY_W-1:0]    key_mem [ENTRIES];
  logic [VAL_W-1:0]    val_mem [ENTRIES];
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    val_q;

  logic                accept;
  logic                go_scan;
  logic                scan_done;
  logic                rd_en;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [CNT_W-1:0]    cap_eff;
  logic [ENTRIES-1:0]  cap_mask;
  logic [ENTRIES-1:0]  occ_mask;
  logic                any_occ;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic                more_occ;
  logic                hit;

  assign accept  = start && (state_r == ST_IDLE);
  assign cap_eff = (32'(cap_r) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(cap_r);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cap_mask[i] = (CNT_W'(i) < cap_eff);
    end
  end

  assign occ_mask = valid_r & cap_mask;
  assign any_occ  = |occ_mask;

  // lowest empty slot within capacity
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (cap_mask[i] && !valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // occupied slot still ahead of the one being checked
  always_comb begin
    more_occ = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((IDX_W'(i) > chk_idx_r) && occ_mask[i]) begin
        more_occ = 1'b1;
      end
    end
  end

  assign rd_en = (state_r == ST_SCAN) && (rd_idx_r < cap_eff);
  assign hit   = chk_vld_r && valid_r[chk_idx_r] && (key_q == key_r);

  always_comb begin
    go_scan = 1'b0;
    case (in_opcode) inside
      OP_GET, OP_SET, OP_REMOVE: go_scan = (in_key != KEY_EMPTY);
      OP_ENUM:                   go_scan = any_occ;
      default:                   go_scan = 1'b0;
    endcase
  end

  // end of a scan: hit or exhausted for lookups, last occupied slot for enumerate
  always_comb begin
    if (op_r == OP_ENUM) begin
      scan_done = chk_vld_r && valid_r[chk_idx_r] && !more_occ;
    end else begin
      scan_done = hit || !rd_en;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && go_scan) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    rd_idx_nxt    = rd_idx_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    mem_we        = 1'b0;
    mem_wa        = chk_idx_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = 1'b0;
    out_key_nxt   = out_key_r;
    out_val_nxt   = '0;
    out_cnt_nxt   = count_r;
    out_last_nxt  = 1'b1;

    if (accept) begin
      op_nxt     = op_t'(in_opcode);
      key_nxt    = in_key;
      val_nxt    = in_value;
      rd_idx_nxt = '0;
      if (!go_scan) begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = in_key;
        if (in_opcode == OP_CLEAR) begin
          valid_nxt   = '0;
          count_nxt   = '0;
          out_ok_nxt  = 1'b1;
          out_cnt_nxt = '0;
        end
      end
    end else if (state_r == ST_SCAN) begin
      if (rd_en) begin
        rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = rd_idx_r[IDX_W-1:0];
      end
      out_key_nxt = key_r;
      if (op_r == OP_ENUM) begin
        if (chk_vld_r && valid_r[chk_idx_r]) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_key_nxt   = key_q;
          out_val_nxt   = val_q;
          out_last_nxt  = !more_occ;
        end
      end else if (scan_done) begin
        out_valid_nxt = 1'b1;
        case (op_r)
          OP_GET: begin
            out_ok_nxt  = hit;
            out_val_nxt = hit ? val_q : '0;
          end
          OP_SET: begin
            if (hit) begin
              mem_we     = 1'b1;
              out_ok_nxt = 1'b1;
            end else if ((count_r < cap_eff) && free_found) begin
              mem_we            = 1'b1;
              mem_wa            = free_idx;
              valid_nxt[free_idx] = 1'b1;
              count_nxt         = count_r + CNT_W'(1);
              out_ok_nxt        = 1'b1;
              out_cnt_nxt       = count_r + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              valid_nxt[chk_idx_r] = 1'b0;
              out_ok_nxt           = 1'b1;
              if (count_r != '0) begin
                count_nxt   = count_r - CNT_W'(1);
                out_cnt_nxt = count_r - CNT_W'(1);
              end
            end
          end
          default: out_ok_nxt = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      cap_r       <= CAP_W'(ENTRIES);
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_capacity_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    rd_idx_r   <= rd_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_ok_r   <= out_ok_nxt;
    out_key_r  <= out_key_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  // key and value memories: write back on set, read one slot per scan cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= key_r;
      val_mem[mem_wa] <= val_r;
    end
    if (rd_en) begin
      key_q <= key_mem[rd_idx_r[IDX_W-1:0]];
      val_q <= val_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_key_out     = out_key_r;
  assign out_value_out   = out_val_r;
  assign out_entry_count = out_cnt_r;
  assign out_last        = out_last_r;

endmodule

// File: hw/rtl/kvm_checker.sv
`timescale 1ns / 1ps

module kvm_checker
  import kvm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_ok,
  input logic [VAL_W-1:0] out_value_out,
  input logic [CNT_W-1:0] out_entry_count,
  input logic             out_last
);

  // a failed transaction always ends with that single result
  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_last)
    else $error("failed result not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_entry_count) <= ENTRIES))
    else $error("entry count above table depth");

  // an accepted transaction either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction dropped");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  a_enum_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_value_out == '0))
    else $error("value on failed result");

endmodule

bind linear_key_value_map_top kvm_checker u_kvm_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import kvm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN_MIN = OP_ENUM + OP_W'(1);
  localparam logic [OP_W-1:0] OP_UNKNOWN_MAX = {OP_W{1'b1}};
  localparam int KEY_POOL = 20;
  localparam int RANDOM_PER_PHASE = 85;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             last;
  } map_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  in_opcode = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_ok;
  logic [KEY_W-1:0] out_key_out;
  logic [VAL_W-1:0] out_value_out;
  logic [CNT_W-1:0] out_entry_count;
  logic             out_last;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_capacity_in_use = '0;

  // Shadow copy of the map contents and the capacity register
  logic [KEY_W-1:0] slot_keys [ENTRIES];
  logic [VAL_W-1:0] slot_vals [ENTRIES];
  logic [CNT_W-1:0] used_slots;
  logic [CAP_W-1:0] capacity;

  map_result_t      pending_results [$];
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  int               idle_pct = 0;
  int               errors = 0;

  always #4 clk = ~clk;

  linear_key_value_map_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_key              (in_key),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_ok              (out_ok),
    .out_key_out         (out_key_out),
    .out_value_out       (out_value_out),
    .out_entry_count     (out_entry_count),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  function automatic void queue_result(logic ok, logic [KEY_W-1:0] key,
                                       logic [VAL_W-1:0] value, logic last);
    map_result_t r;
    r.ok    = ok;
    r.key   = key;
    r.value = value;
    r.count = used_slots;
    r.last  = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_map_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] value);
    int span;
    int hit;
    int free;
    int n;
    logic reserved;
    span = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
    reserved = (key == KEY_EMPTY);
    hit = -1;
    free = -1;
    for (int s = 0; s < span; s++) begin
      if (hit < 0 && slot_keys[s] == key) hit = s;
      if (free < 0 && slot_keys[s] == KEY_EMPTY) free = s;
    end
    if (reserved) hit = -1;
    case (op)
      OP_GET: begin
        if (hit >= 0) queue_result(1'b1, key, slot_vals[hit], 1'b1);
        else queue_result(1'b0, key, '0, 1'b1);
      end
      OP_SET: begin
        if (!reserved && hit < 0 && int'(used_slots) < span && free >= 0) begin
          hit = free;
          used_slots++;
        end
        if (hit >= 0) begin
          slot_keys[hit] = key;
          slot_vals[hit] = value;
          queue_result(1'b1, key, '0, 1'b1);
        end else begin
          queue_result(1'b0, key, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          slot_keys[hit] = KEY_EMPTY;
          if (used_slots > 0) used_slots--;
          queue_result(1'b1, key, '0, 1'b1);
        end else begin
          queue_result(1'b0, key, '0, 1'b1);
        end
      end
      OP_CLEAR: begin
        for (int s = 0; s < ENTRIES; s++) slot_keys[s] = KEY_EMPTY;
        used_slots = '0;
        queue_result(1'b1, key, '0, 1'b1);
      end
      OP_ENUM: begin
        n = 0;
        for (int s = 0; s < span; s++) begin
          if (slot_keys[s] != KEY_EMPTY) begin
            queue_result(1'b1, slot_keys[s], slot_vals[s], 1'b0);
            n++;
          end
        end
        if (n == 0) queue_result(1'b0, key, '0, 1'b1);
        else pending_results[$].last = 1'b1;
      end
      default: queue_result(1'b0, key, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding, key_out %0h", out_key_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 64'(want.ok), 64'(out_ok));
        check_field("key_out", 64'(want.key), 64'(out_key_out));
        check_field("value_out", 64'(want.value), 64'(out_value_out));
        check_field("entry_count", 64'(want.count), 64'(out_entry_count));
        check_field("last", 64'(want.last), 64'(out_last));
      end
    end
  end

  function automatic int idle_gap();
    int g;
    g = 0;
    while (g < 20 && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // Returns at the edge where the transaction is taken; start stays high.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= op;
    in_key    <= key;
    in_value  <= value;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    predict_map_op(op, key, value);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while ((pending_results.size() != 0 || busy) && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= 5000) begin
      $error("timed out with %0d results outstanding", pending_results.size());
      errors++;
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_capacity_in_use <= cap;
    cfg_we              <= 1'b1;
    @(posedge clk);
    capacity = cap;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(KEY_POOL - 1)];
  endfunction

  task automatic test_basic_ops();
    idle_pct = 20;
    send_item(OP_GET, 32'h0000_1234, '0);
    send_item(OP_ENUM, 32'h0000_00aa, '0);
    send_item(OP_SET, '0, '0);
    send_item(OP_SET, 32'hffff_fffe, 32'hffff_ffff);
    send_item(OP_SET, '0, 32'h5a5a_a5a5);
    send_item(OP_GET, '0, '0);
    send_item(OP_GET, 32'hffff_fffe, 32'hffff_ffff);
    // Reserved key: no effect on the map
    send_item(OP_GET, KEY_EMPTY, '0);
    send_item(OP_SET, KEY_EMPTY, 32'h1111_2222);
    send_item(OP_REMOVE, KEY_EMPTY, '0);
    send_item(OP_REMOVE, 32'hffff_fffe, '0);
    send_item(OP_REMOVE, 32'hffff_fffe, '0);
    send_item(OP_UNKNOWN_MIN, 32'h8000_0001, 32'hdead_beef);
    send_item(OP_UNKNOWN_MAX, 32'h7fff_fffe, '0);
    send_item(OP_ENUM, 32'h0000_0055, '0);
    send_item(OP_CLEAR, 32'hcafe_f00d, '1);
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    send_item(OP_SET, 32'h0000_0010, 32'h0000_0001);
    send_item(OP_ENUM, 32'h0000_0011, '0);
    write_capacity(5'd2);
    send_item(OP_SET, 32'h0000_00a0, 32'h0000_000a);
    send_item(OP_SET, 32'h0000_00b0, 32'h0000_000b);
    send_item(OP_SET, 32'h0000_00c0, 32'h0000_000c);
    send_item(OP_ENUM, '0, '0);
    send_item(OP_REMOVE, 32'h0000_00a0, '0);
    // Above the depth the capacity acts as the full table
    write_capacity('1);
    send_item(OP_SET, 32'h0000_00c0, 32'h0000_00cc);
    // Slot 1 lies past the capacity now: kept and counted, never searched
    write_capacity(5'd1);
    send_item(OP_ENUM, '0, '0);
    send_item(OP_GET, 32'h0000_00b0, '0);
    send_item(OP_SET, 32'h0000_00d0, 32'h0000_000d);
    send_item(OP_CLEAR, '0, '0);
  endtask

  task automatic test_random_traffic();
    int pct [4];
    logic [CAP_W-1:0] caps [4];
    int r;
    pct = '{0, 45, 0, 36};
    caps = '{5'd16, 5'($urandom_range(1, 15)), 5'($urandom_range(17, 31)), 5'd16};
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = 32'hffff_fffe;
    for (int ph = 0; ph < 4; ph++) begin
      write_capacity(caps[ph]);
      idle_pct = pct[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 30) send_item(OP_GET, pick_key(), $urandom);
        else if (r < 62) send_item(OP_SET, pick_key(), $urandom);
        else if (r < 80) send_item(OP_REMOVE, pick_key(), $urandom);
        else if (r < 82) send_item(OP_CLEAR, pick_key(), $urandom);
        else if (r < 92) send_item(OP_ENUM, pick_key(), $urandom);
        else if (r < 96)
          send_item(OP_W'($urandom_range(OP_UNKNOWN_MIN, OP_UNKNOWN_MAX)), pick_key(), $urandom);
        else send_item(OP_W'($urandom_range(OP_GET, OP_REMOVE)), KEY_EMPTY, $urandom);
      end
    end
  endtask

  initial begin
    for (int s = 0; s < ENTRIES; s++) begin
      slot_keys[s] = KEY_EMPTY;
      slot_vals[s] = '0;
    end
    used_slots = '0;
    capacity = CAP_W'(ENTRIES);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_capacity_limits();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/kvm_pkg.sv
hw/rtl/linear_key_value_map_top.sv
hw/rtl/kvm_checker.sv
test/tb.sv
